[hw/rtl/nqueens_first_solution_unit_assert.svh]
// Assertion macros for the N-queens first solution unit.
`ifndef NQUEENS_FIRST_SOLUTION_UNIT_ASSERT_SVH
`define NQUEENS_FIRST_SOLUTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define NQFS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante.
`define NQFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NQFS_ASSERT_SAME(label, ante, cons, msg)
`define NQFS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[hw/rtl/nqfs_pkg.sv]
// Shared types and constants for the N-queens first solution unit.
package nqfs_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned ROW_W  = 4;
  localparam int unsigned COL_W  = 5;

  // Default largest board size
  localparam int unsigned MAX_N_DEF = 16;

  // Search sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_BACK,
    S_OUT_REQ,
    S_OUT_LOAD,
    S_NONE
  } state_e;

endpackage

[hw/rtl/nqfs_stack_ram.sv]
// Level stack memory: one write port, one read port with registered data.
module nqfs_stack_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data, hold it between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/nqueens_first_solution_unit.sv]
// N-queens first solution unit: bitmask backtracking search over a level stack memory.
// A queen placed runs S_READ, S_EVAL; a backtrack step S_EVAL, S_BACK, S_READ; a result row S_OUT_REQ, S_OUT_LOAD.
// Throughput: one search at a time on the read-evaluate-write loop of the stack memory;
// output stalls hold each result row in S_OUT_LOAD.
// Size zero or above MAX_N: one not-found item, issued from S_NONE through the output register.
// Reset clears the sequencer and output valid; stack contents are not cleared.
`include "nqueens_first_solution_unit_assert.svh"
module nqueens_first_solution_unit #(
  parameter int unsigned MAX_N = nqfs_pkg::MAX_N_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [nqfs_pkg::SIZE_W-1:0] board_size_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [nqfs_pkg::ROW_W-1:0]  row_o,
  output logic [nqfs_pkg::COL_W-1:0]  column_o,
  output logic                        last_o
);

  localparam int unsigned LW = $clog2(MAX_N);
  localparam int unsigned EW = 4 * MAX_N;
  localparam int unsigned CW = (LW + 1 > nqfs_pkg::SIZE_W) ? LW + 1 : nqfs_pkg::SIZE_W;
  localparam logic [MAX_N-1:0] ONE_M = MAX_N'(1);

  nqfs_pkg::state_e state_q, state_d;
  logic [LW-1:0] level_q, level_d;
  logic [LW-1:0] row_q, row_d;
  logic [nqfs_pkg::SIZE_W-1:0] n_q, n_d;
  logic [MAX_N-1:0] full_q, full_d;

  logic                       out_valid_q, out_valid_d;
  logic                       found_q, found_d;
  logic [nqfs_pkg::ROW_W-1:0] row_out_q, row_out_d;
  logic [nqfs_pkg::COL_W-1:0] column_q, column_d;
  logic                       last_q, last_d;

  logic          we, re;
  logic [LW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [MAX_N-1:0] rd_col, rd_left, rd_right, rd_cand;
  logic [MAX_N-1:0] bit_sel, nc, nl, nr, full_new;
  logic [LW:0]      lvl_inc, row_inc;
  logic             size_bad, slot_free;

  // Map a one-hot mask to its 1-based column
  function automatic logic [nqfs_pkg::COL_W-1:0] encode_column(logic [MAX_N-1:0] onehot);
    logic [nqfs_pkg::COL_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < MAX_N; i++) begin
      if (onehot[i]) begin
        pos = pos | nqfs_pkg::COL_W'(i + 1);
      end
    end
    return pos;
  endfunction

  nqfs_stack_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_N)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Split the stack entry and form the next level's masks
  assign rd_col   = rdata[MAX_N-1:0];
  assign rd_left  = rdata[2*MAX_N-1:MAX_N];
  assign rd_right = rdata[3*MAX_N-1:2*MAX_N];
  assign rd_cand  = rdata[4*MAX_N-1:3*MAX_N];
  assign bit_sel  = rd_cand & ((~rd_cand) + ONE_M);
  assign nc       = rd_col | bit_sel;
  assign nl       = ((rd_left | bit_sel) << 1) & full_q;
  assign nr       = (rd_right | bit_sel) >> 1;
  assign lvl_inc  = {1'b0, level_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;

  // Decode the incoming size
  always_comb begin
    for (int i = 0; i < MAX_N; i++) begin
      full_new[i] = i < int'(board_size_i);
    end
  end
  assign size_bad  = (board_size_i == '0) || (int'(board_size_i) > int'(MAX_N));
  assign slot_free = !out_valid_q || !out_stall_i;

  // Sequence the search and the result rows
  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    row_d       = row_q;
    n_d         = n_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    row_out_d   = row_out_q;
    column_d    = column_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = level_q;
    wdata       = '0;
    re          = 1'b0;
    raddr       = level_q;
    case (state_q)
      nqfs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          n_d    = board_size_i;
          full_d = full_new;
          if (size_bad) begin
            state_d = nqfs_pkg::S_NONE;
          end else begin
            we      = 1'b1;
            waddr   = '0;
            wdata   = {full_new, {(3 * MAX_N){1'b0}}};
            level_d = '0;
            state_d = nqfs_pkg::S_READ;
          end
        end
      end
      nqfs_pkg::S_READ: begin
        re      = 1'b1;
        state_d = nqfs_pkg::S_EVAL;
      end
      nqfs_pkg::S_EVAL: begin
        if (rd_cand == '0) begin
          if (level_q == '0) begin
            state_d = nqfs_pkg::S_NONE;
          end else begin
            // Drop back one row and fetch its candidates
            level_d = level_q - 1'b1;
            re      = 1'b1;
            raddr   = level_q - 1'b1;
            state_d = nqfs_pkg::S_BACK;
          end
        end else if (CW'(lvl_inc) >= CW'(n_q)) begin
          row_d   = '0;
          state_d = nqfs_pkg::S_OUT_REQ;
        end else begin
          // Advance: push the next row's masks
          we      = 1'b1;
          waddr   = lvl_inc[LW-1:0];
          wdata   = {full_q & ~(nc | nl | nr), nr, nl, nc};
          level_d = lvl_inc[LW-1:0];
          state_d = nqfs_pkg::S_READ;
        end
      end
      nqfs_pkg::S_BACK: begin
        // Clear the column just tried in this row
        we      = 1'b1;
        waddr   = level_q;
        wdata   = {rd_cand & (rd_cand - ONE_M), rd_right, rd_left, rd_col};
        state_d = nqfs_pkg::S_READ;
      end
      nqfs_pkg::S_OUT_REQ: begin
        re      = 1'b1;
        raddr   = row_q;
        state_d = nqfs_pkg::S_OUT_LOAD;
      end
      nqfs_pkg::S_OUT_LOAD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          found_d     = 1'b1;
          row_out_d   = nqfs_pkg::ROW_W'(row_q);
          column_d    = encode_column(bit_sel);
          last_d      = CW'(row_inc) == CW'(n_q);
          if (CW'(row_inc) == CW'(n_q)) begin
            state_d = nqfs_pkg::S_IDLE;
          end else begin
            row_d   = row_inc[LW-1:0];
            state_d = nqfs_pkg::S_OUT_REQ;
          end
        end
      end
      nqfs_pkg::S_NONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          row_out_d   = '0;
          column_d    = '0;
          last_d      = 1'b1;
          state_d     = nqfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = nqfs_pkg::S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nqfs_pkg::S_IDLE;
      level_q     <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold search size and output payload
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    full_q    <= full_d;
    found_q   <= found_d;
    row_out_q <= row_out_d;
    column_q  <= column_d;
    last_q    <= last_d;
  end

  assign in_stall_o  = state_q != nqfs_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign row_o       = row_out_q;
  assign column_o    = column_q;
  assign last_o      = last_q;

  // Checks on the search and result logic
  `NQFS_ASSERT_SAME(a_level_below_size, state_q == nqfs_pkg::S_EVAL, CW'(lvl_inc) <= CW'(n_q), "search level reached board size")
  `NQFS_ASSERT_SAME(a_none_is_last, out_valid_o && !found_o, last_o && column_o == '0 && row_o == '0, "not-found item malformed")
  `NQFS_ASSERT_SAME(a_found_has_column, out_valid_o && found_o && (MAX_N < 32), column_o != '0, "found item without column")
  `NQFS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted while search pending")

endmodule
